### design/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg: shared types and constants of the keypad scan debouncer
// Command/status bundles between controller and datapath, result codes and
// field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

    localparam int SAMPLE_W = 12;   // column_samples field
    localparam int KEY_W    = 4;    // key_number field
    localparam int WIN_W    = 4;    // window_length register
    localparam int STATE_W  = 2;    // key_state field

    // key_state codes
    localparam logic [STATE_W-1:0] KS_OFF       = 2'd0;
    localparam logic [STATE_W-1:0] KS_ON        = 2'd1;
    localparam logic [STATE_W-1:0] KS_TRANSIENT = 2'd2;
    localparam logic [STATE_W-1:0] KS_INVALID   = 2'd3;

    // func codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_WINDOW = 1'b0;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd5;

    typedef struct packed {
        logic tick_write;   // store samples, advance pointer
        logic start_query;  // latch key, load walk index and count
        logic issue;        // read one history entry, step index back
        logic load_out;     // move result into output register
    } t_ksd_cmd;

    typedef struct packed {
        logic key_ok;       // key_number on the input is in range
        logic last_read;    // one read left in the walk
        logic out_free;     // output register can take a word
    } t_ksd_sts;

endpackage

`default_nettype wire

### design/ksd_ctrl.sv
// ----------------------------------------------------------------------------
// ksd_ctrl: sequencer of the keypad scan debouncer
// Accepts words in idle, walks the history for queries and hands the result
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_valid,
    input  wire              i_func,
    output logic             o_s_ready,
    input  ksd_pkg::t_ksd_sts i_sts,
    output ksd_pkg::t_ksd_cmd o_cmd
);
    import ksd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_s_ready = (r_state == ST_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.tick_write  = accept && (i_func == FUNC_TICK);
        o_cmd.start_query = accept && (i_func == FUNC_QUERY);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start_query) begin
                    n_state = i_sts.key_ok ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_read) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;   // last read data lands this cycle
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/ksd_dpath.sv
// ----------------------------------------------------------------------------
// ksd_dpath: datapath of the keypad scan debouncer
// Sample history memory with per-entry valid bits, ring pointer, walk index,
// agreement flags and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_dpath #(
    parameter int HISTORY_DEPTH = 10,
    parameter int ROW_COUNT     = 4,
    parameter int COLUMN_COUNT  = 3
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ksd_pkg::t_ksd_cmd            i_cmd,
    output ksd_pkg::t_ksd_sts            o_sts,
    input  wire [ksd_pkg::SAMPLE_W-1:0]  i_samples,
    input  wire [ksd_pkg::KEY_W-1:0]     i_key,
    input  wire [ksd_pkg::WIN_W-1:0]     i_window,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [ksd_pkg::STATE_W-1:0]  o_key_state
);
    import ksd_pkg::*;

    localparam int KEY_COUNT = ROW_COUNT * COLUMN_COUNT;
    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int BIT_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_SPAN  = 1 << KEY_W;

    // history store
    logic [KEY_COUNT-1:0]     mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [KEY_COUNT-1:0]     r_rd_data;
    logic                     r_rd_vld;
    logic                     r_rd_pend;

    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] r_idx;
    logic [WIN_W-1:0] r_remain;
    logic [WIN_W-1:0] win;
    logic [BIT_W-1:0] r_bit;
    logic             r_key_ok;
    logic             r_seen_rel;
    logic             r_seen_prs;
    logic             sample_bit;
    logic             key_ok;
    logic [KEY_W-1:0] key_m1;
    logic [63:0]      samp_ext;
    logic [STATE_W-1:0] result;

    // key number minus one -> bit position in a stored word
    logic [BIT_W-1:0] bit_tbl [KEY_SPAN];
    for (genvar k = 0; k < KEY_SPAN; k++) begin : g_map
        localparam int B = (k < KEY_COUNT) ?
            ((ROW_COUNT - 1 - k / COLUMN_COUNT) * COLUMN_COUNT + k % COLUMN_COUNT) : 0;
        assign bit_tbl[k] = BIT_W'(B);
    end

    assign key_m1   = i_key - KEY_W'(1);
    assign key_ok   = (i_key != '0) && (32'(i_key) <= KEY_COUNT);
    assign samp_ext = 64'(i_samples);

    // window clamp to 1..depth
    always_comb begin
        priority if (i_window == '0) begin
            win = WIN_W'(1);
        end else if (32'(i_window) > HISTORY_DEPTH) begin
            win = WIN_W'(HISTORY_DEPTH);
        end else begin
            win = i_window;
        end
    end

    assign n_wp = (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_write) begin
            mem[n_wp] <= samp_ext[KEY_COUNT-1:0];
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_wp      <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.issue;
            if (i_cmd.tick_write) begin
                r_wp          <= n_wp;
                r_valid[n_wp] <= 1'b1;
            end
        end
    end

    // unwritten entries read as released
    assign sample_bit = r_rd_vld ? r_rd_data[r_bit] : 1'b1;

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[r_idx];
        if (i_cmd.start_query) begin
            r_idx      <= r_wp;
            r_remain   <= win;
            r_bit      <= bit_tbl[key_m1];
            r_key_ok   <= key_ok;
            r_seen_rel <= 1'b0;
            r_seen_prs <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_idx    <= (r_idx == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_idx - PTR_W'(1);
                r_remain <= r_remain - WIN_W'(1);
            end
            if (r_rd_pend) begin
                if (sample_bit) begin
                    r_seen_rel <= 1'b1;
                end else begin
                    r_seen_prs <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        priority if (!r_key_ok) begin
            result = KS_INVALID;
        end else if (!r_seen_prs) begin
            result = KS_OFF;
        end else if (!r_seen_rel) begin
            result = KS_ON;
        end else begin
            result = KS_TRANSIENT;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_key_state <= result;
        end
    end

    assign o_sts.key_ok    = key_ok;
    assign o_sts.last_read = (r_remain == WIN_W'(1));
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

### design/keypad_scan_debounce_core.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_core: key matrix debouncer, top level
// Stores scan snapshots in a ring history and answers per-key state queries.
// ----------------------------------------------------------------------------
// Two word kinds arrive on the slave stream, told apart by s_axis_tuser.
// A scan tick (tuser 0) stores the twelve active-low column samples in the
// next slot of a HISTORY_DEPTH-deep ring and gives no output word. A query
// (tuser 1) names key 1..ROW_COUNT*COLUMN_COUNT and is answered on the
// master stream with off, on, transient or invalid. A valid query walks the
// newest window_length entries (clamped to 1..HISTORY_DEPTH) through the
// single read port of the history memory, one entry per cycle, then a drain
// state takes the last read data and a finish state loads the result into
// the output register; no new word is taken until the result is loaded. An
// out-of-range key skips the walk and goes straight to the finish state.
// A result still waiting in the output register holds the sequencer in its
// last state until the master side takes it. The slave side is ready
// whenever the sequencer is idle, also while a result waits in the output
// register. After reset every history slot reads as released, by per-slot
// valid bits. window_length sits at APB byte address 0, reset value 5.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce_core #(
    parameter int HISTORY_DEPTH = 10,
    parameter int ROW_COUNT     = 4,
    parameter int COLUMN_COUNT  = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [15:0]  s_axis_tdata,   // [11:0] column_samples, [15:12] key_number
    input  wire         s_axis_tuser,   // [0] func
    // master stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] key_state, [7:2] zero
    // APB register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ksd_pkg::*;

    t_ksd_cmd           cmd;
    t_ksd_sts           sts;
    logic [WIN_W-1:0]   r_window;
    logic [STATE_W-1:0] key_state;

    // ---- register port: word index is paddr[2], low bits ignored
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW) ? 32'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW)) begin
            r_window <= pwdata[WIN_W-1:0];
        end
    end

    // ---- sequencer
    ksd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_func    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // ---- history, walk and output register
    ksd_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ROW_COUNT     (ROW_COUNT),
        .COLUMN_COUNT  (COLUMN_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_samples   (s_axis_tdata[SAMPLE_W-1:0]),
        .i_key       (s_axis_tdata[SAMPLE_W+KEY_W-1:SAMPLE_W]),
        .i_window    (r_window),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_key_state (key_state)
    );

    assign m_axis_tdata = 8'(key_state);

`ifndef SYNTHESIS
    // a scan tick never produces an output word
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_TICK) && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("scan tick produced an output word");

    // out-of-range key: invalid word loaded at the edge after acceptance
    a_invalid_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY) && !m_axis_tvalid
         && ((s_axis_tdata[15:12] == '0)
             || (32'(s_axis_tdata[15:12]) > ROW_COUNT * COLUMN_COUNT)))
        |=> ##1 (m_axis_tvalid && (m_axis_tdata[1:0] == KS_INVALID)))
        else $error("invalid key not answered as invalid");

    // sequencer busy means no new word accepted
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY)) |=> !s_axis_tready)
        else $error("word accepted while a query is in flight");
`endif

endmodule

`default_nettype wire

### verif/keypad_scan_debounce_core_tb.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_core_tb: self-checking bench for the key debouncer
// Streams scan ticks and key queries into the core and predicts every
// key_state word from a private copy of the sample history. Window length is
// changed over APB between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksd_pkg::*;

    localparam int HISTORY_DEPTH = 10;
    localparam int ROW_COUNT     = 4;
    localparam int COLUMN_COUNT  = 3;
    localparam int KEY_COUNT     = ROW_COUNT * COLUMN_COUNT;

    // margin after the last answer for a walk to finish before APB writes
    localparam int SETTLE_CYCLES = 16;
    localparam int SEG_COUNT     = 9;
    localparam int SEG_WORDS     = 148;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

    // ------------------------------------------------------------------------
    // Debounce predictor and store of pending key_state words
    // ------------------------------------------------------------------------
    class key_debounce_board;
        logic [SAMPLE_W-1:0] snapshots [HISTORY_DEPTH];
        int unsigned         newest;
        logic [WIN_W-1:0]    window_reg;
        logic [STATE_W-1:0]  pending_states [$];
        int unsigned         mismatches;
        int unsigned         ticks_seen;
        int unsigned         queries_seen;
        int unsigned         state_hits [4];

        function new();
            foreach (snapshots[i]) snapshots[i] = '1;   // everything released
            newest     = 0;
            window_reg = WINDOW_RESET;
            mismatches = 0;
            ticks_seen = 0;
            queries_seen = 0;
            foreach (state_hits[i]) state_hits[i] = 0;
        endfunction

        function logic [STATE_W-1:0] debounce_state(logic [KEY_W-1:0] key);
            int unsigned k, bit_pos, span, idx, pressed_n, released_n;
            if (key < 1 || key > KEY_COUNT) return KS_INVALID;
            k = key - 1;
            // key 1 sits in the top row of the sample word
            bit_pos = (ROW_COUNT - 1 - k / COLUMN_COUNT) * COLUMN_COUNT
                      + k % COLUMN_COUNT;
            span = window_reg;
            if (span < 1) span = 1;
            if (span > HISTORY_DEPTH) span = HISTORY_DEPTH;
            idx = newest;
            pressed_n = 0;
            released_n = 0;
            for (int i = 0; i < span; i++) begin
                if (snapshots[idx][bit_pos]) released_n++;
                else pressed_n++;
                idx = (idx == 0) ? HISTORY_DEPTH - 1 : idx - 1;
            end
            if (released_n == span) return KS_OFF;
            if (pressed_n == span) return KS_ON;
            return KS_TRANSIENT;
        endfunction

        // called for every word accepted on the slave side
        function void note_word(logic func, logic [SAMPLE_W-1:0] samples,
                                logic [KEY_W-1:0] key);
            if (func == FUNC_TICK) begin
                newest = (newest == HISTORY_DEPTH - 1) ? 0 : newest + 1;
                snapshots[newest] = samples;
                ticks_seen++;
            end else begin
                pending_states.push_back(debounce_state(key));
                queries_seen++;
            end
        endfunction

        // called for every word accepted on the master side
        function void check_word(logic [7:0] word);
            logic [STATE_W-1:0] want;
            if (pending_states.size() == 0) begin
                $error("key_state: expected no word, actual %0d", word[1:0]);
                mismatches++;
                return;
            end
            want = pending_states.pop_front();
            state_hits[want]++;
            if (word[1:0] !== want) begin
                $error("key_state: expected %0d, actual %0d", want, word[1:0]);
                mismatches++;
            end
            if (word[7:2] !== 6'd0) begin
                $error("tdata pad: expected 0, actual %0h", word[7:2]);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [11:0] column_samples, [15:12] key_number
    logic        s_axis_tuser  = 1'b0; // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [1:0] key_state, [7:2] zero
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    key_debounce_board board;
    int unsigned       send_gap_pct;
    int unsigned       recv_stall_pct;
    int unsigned       cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    keypad_scan_debounce_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ROW_COUNT     (ROW_COUNT),
        .COLUMN_COUNT  (COLUMN_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Receiver: check each accepted word, then pick the next tready.
    // Values read here are the ones from before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            board.check_word(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: a hang or a missing word ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Present one word; tvalid stays high into the next word unless a gap
    // is drawn, so back-to-back words need no extra assignment.
    task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] samples,
                             input logic [KEY_W-1:0] key);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {key, samples};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_word(func, samples, key);
    endtask

    // Stop sending until every pending query is answered, then let any
    // walk or tick in flight finish.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (board.pending_states.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write window_length, then read it back.
    task automatic set_window(input logic [WIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.window_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[WIN_W-1:0] !== value) begin
            $error("window_length: expected %0d, actual %0d", value, prdata[WIN_W-1:0]);
            board.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [WIN_W-1:0]    windows [SEG_COUNT];
        logic [SAMPLE_W-1:0] held_keys;     // active-high: keys currently held
        logic [SAMPLE_W-1:0] samples;
        logic [KEY_W-1:0]    key;

        // extremes first, clamped values included
        windows   = '{4'd1, 4'd9, 4'd0, 4'd10, 4'd15, 4'd5, 4'd3, 4'd7, 4'd2};
        held_keys = '0;
        board     = new();
        send_gap_pct   = 15;
        recv_stall_pct = 64;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -- directed part, window at its reset value of 5 --
        send_word(FUNC_QUERY, 12'h000, 4'd1);    // fresh history: off
        send_word(FUNC_QUERY, 12'hfff, 4'd0);    // key below range
        send_word(FUNC_QUERY, 12'h000, 4'd13);   // one past the last key
        send_word(FUNC_QUERY, 12'h5a5, 4'd15);   // top of the field
        send_word(FUNC_TICK,  12'h000, 4'hf);    // all pressed, key bits ignored
        send_word(FUNC_QUERY, 12'h000, 4'd12);   // one of five pressed: transient
        repeat (4) send_word(FUNC_TICK, 12'h000, 4'h0);
        send_word(FUNC_QUERY, 12'hfff, 4'd1);    // five pressed: on
        send_word(FUNC_QUERY, 12'hfff, 4'd6);
        send_word(FUNC_TICK,  12'hfff, 4'ha);
        send_word(FUNC_QUERY, 12'h000, 4'd7);    // released once: transient
        send_word(FUNC_TICK,  12'hdff, 4'h5);    // only key 1 pressed
        send_word(FUNC_QUERY, 12'h000, 4'd1);
        send_word(FUNC_QUERY, 12'h000, 4'd2);
        wait_quiet();
        set_window(4'd0);                        // treated as one entry
        send_word(FUNC_QUERY, 12'h000, 4'd2);    // newest released: off
        send_word(FUNC_QUERY, 12'h000, 4'd1);    // newest pressed: on
        wait_quiet();
        set_window(4'd15);                       // clamped to the full history
        send_word(FUNC_QUERY, 12'h000, 4'd3);
        send_word(FUNC_QUERY, 12'h000, 4'd14);

        // -- random part: three idle profiles, three window settings each --
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 3) begin
                send_gap_pct   = 64;
                recv_stall_pct = 15;
            end else if (seg == 6) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            wait_quiet();
            set_window(windows[seg]);
            for (int n = 0; n < SEG_WORDS; n++) begin
                // hold off until the result side has drained
                if (n == SEG_WORDS / 2) wait_quiet();
                if ($urandom_range(99) < 55) begin
                    // held keys change now and then, with some contact bounce
                    if ($urandom_range(99) < 12)
                        held_keys = held_keys ^ (12'(1) << $urandom_range(11));
                    if ($urandom_range(99) < 3)
                        held_keys = 12'($urandom);
                    samples = ~held_keys;
                    if ($urandom_range(99) < 20)
                        samples = samples ^ (12'(1) << $urandom_range(11));
                    if ($urandom_range(99) < 5)
                        samples = 12'($urandom);
                    send_word(FUNC_TICK, samples, 4'($urandom));
                end else begin
                    key = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1))
                                                    : 4'($urandom);
                    send_word(FUNC_QUERY, 12'($urandom), key);
                end
            end
        end

        wait_quiet();
        $display("Ran %0d scan ticks and %0d queries over %0d window settings,",
                 board.ticks_seen, board.queries_seen, SEG_COUNT + 2);
        $display("answers: %0d off, %0d on, %0d transient, %0d invalid key.",
                 board.state_hits[KS_OFF], board.state_hits[KS_ON],
                 board.state_hits[KS_TRANSIENT], board.state_hits[KS_INVALID]);
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
